// ===== sv/i2cms_pkg.sv =====
// i2cms_pkg: command codes, delay lengths and stream widths for the i2c master
// bit sequencer; no dependencies
`default_nettype none

package i2cms_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_WRITE = 3'd5,
    CMD_READ  = 3'd6
  } cmd_e;

  localparam int unsigned UnitTicksW = 16;
  localparam logic [UnitTicksW-1:0] UnitTicksRst = 16'd16;

  localparam logic [2:0] UnitsLong  = 3'd4;
  localparam logic [2:0] UnitsShort = 3'd2;
  localparam logic [2:0] UnitsOne   = 3'd1;

  localparam logic [3:0] BitsPerByte = 4'd8;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

endpackage

`default_nettype wire

// ===== sv/i2c_master_bit_sequencer_core.sv =====
// i2c_master_bit_sequencer_core: one clock tick per request, drives scl/sda
// and reports busy, done and the read byte; depends on i2cms_pkg
// result: registered, valid in the cycle after the request is accepted
// throughput: 1 request per cycle, held only by back-pressure on the result
// register (a new request is taken while the result is being taken)
// reset: asynchronous, active low; idle, scl high, sda high and driven,
// unit_ticks back to 16
`default_nettype none

module i2c_master_bit_sequencer_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // config
  input  wire                              cfg_we_i,
  input  wire [i2cms_pkg::UnitTicksW-1:0]  cfg_wdata_i,
  // request stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] action, [10:3] write_byte, [11] sda_sample, [15:12] zero
  input  wire [i2cms_pkg::InDataW-1:0]     s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] read_data, [15:13] zero
  output logic [i2cms_pkg::OutDataW-1:0]   m_axis_tdata
);
  import i2cms_pkg::*;

  logic [UnitTicksW-1:0] unit_ticks_q;
  cmd_e                  cmd_q, cmd_d;
  logic [1:0]            phase_q, phase_d;
  logic [3:0]            bit_cnt_q, bit_cnt_d;
  logic [UnitTicksW-1:0] tick_cnt_q, tick_cnt_d;
  logic [2:0]            unit_cnt_q, unit_cnt_d;
  logic [7:0]            shift_q, shift_d;
  logic                  scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;

  logic [2:0]            in_action;
  logic [7:0]            in_wbyte;
  logic                  in_sda;
  logic                  req_fire;

  logic [UnitTicksW-1:0] lim;
  logic [UnitTicksW-1:0] tick_inc;
  logic                  tick_wrap;
  logic [2:0]            unit_inc;
  logic [2:0]            units;
  logic                  dly_done;
  logic                  fin;
  logic [3:0]            bit_inc;
  logic [7:0]            rd_byte;
  logic [OutDataW-1:0]   out_data_d;

  assign in_action = s_axis_tdata[2:0];
  assign in_wbyte  = s_axis_tdata[10:3];
  assign in_sda    = s_axis_tdata[11];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign req_fire      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // delay unit counter
  assign lim       = (unit_ticks_q == '0) ? {{(UnitTicksW-1){1'b0}}, 1'b1} : unit_ticks_q;
  assign tick_inc  = tick_cnt_q + 1'b1;
  assign tick_wrap = tick_inc >= lim;
  assign unit_inc  = tick_wrap ? unit_cnt_q + 3'd1 : unit_cnt_q;
  assign bit_inc   = bit_cnt_q + 4'd1;

  always_comb begin
    unique case (cmd_q)
      CMD_START, CMD_STOP: units = UnitsLong;
      CMD_READ:            units = (phase_q == 2'd0) ? UnitsShort : UnitsOne;
      default:             units = UnitsShort;
    endcase
  end

  assign dly_done = unit_inc >= units;

  always_comb begin
    cmd_d      = cmd_q;
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    tick_cnt_d = tick_cnt_q;
    unit_cnt_d = unit_cnt_q;
    shift_d    = shift_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    drv_d      = drv_q;
    fin        = 1'b0;

    if (cmd_q == CMD_IDLE) begin
      if (in_action != CMD_IDLE && in_action != 3'd7) begin
        cmd_d      = cmd_e'(in_action);
        phase_d    = 2'd0;
        bit_cnt_d  = '0;
        tick_cnt_d = '0;
        unit_cnt_d = '0;
        unique case (in_action)
          CMD_START: begin
            scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
          end
          CMD_STOP: begin
            scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1;
          end
          CMD_ACK: begin
            scl_d = 1'b0; sda_d = 1'b0; drv_d = 1'b1;
          end
          CMD_NACK: begin
            scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b1;
          end
          CMD_WRITE: begin
            scl_d   = 1'b0; drv_d = 1'b1;
            sda_d   = in_wbyte[7];
            shift_d = {in_wbyte[6:0], 1'b0};
          end
          default: begin
            scl_d   = 1'b0; sda_d = 1'b1; drv_d = 1'b0;
            shift_d = '0;
          end
        endcase
      end
    end else begin
      tick_cnt_d = tick_wrap ? '0 : tick_inc;
      unit_cnt_d = unit_inc;
      if (dly_done) begin
        tick_cnt_d = '0;
        unit_cnt_d = '0;
        unique case (cmd_q)
          CMD_START: begin
            if (phase_q == 2'd0) begin
              sda_d = 1'b0; phase_d = 2'd1;
            end else begin
              scl_d = 1'b0; fin = 1'b1;
            end
          end
          CMD_STOP: begin
            if (phase_q == 2'd0) begin
              sda_d = 1'b1; phase_d = 2'd1;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_ACK, CMD_NACK: begin
            if (phase_q == 2'd0) begin
              scl_d = 1'b1; phase_d = 2'd1;
            end else begin
              scl_d = 1'b0; fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_q == 2'd0) begin
              scl_d = 1'b1; phase_d = 2'd1;
            end else if (phase_q == 2'd1) begin
              scl_d = 1'b0; phase_d = 2'd2;
            end else begin
              bit_cnt_d = bit_inc;
              if (bit_inc >= BitsPerByte) begin
                fin = 1'b1;
              end else begin
                sda_d   = shift_q[7];
                shift_d = {shift_q[6:0], 1'b0};
                phase_d = 2'd0;
              end
            end
          end
          CMD_READ: begin
            if (phase_q == 2'd0) begin
              scl_d   = 1'b1;
              shift_d = {shift_q[6:0], in_sda};
              phase_d = 2'd1;
            end else begin
              bit_cnt_d = bit_inc;
              if (bit_inc >= BitsPerByte) begin
                fin = 1'b1;
              end else begin
                scl_d   = 1'b0;
                phase_d = 2'd0;
              end
            end
          end
          default: fin = 1'b1;
        endcase
      end
      if (fin) begin
        cmd_d   = CMD_IDLE;
        phase_d = 2'd0;
      end
    end
  end

  assign rd_byte = (fin && cmd_q == CMD_READ) ? shift_d : 8'd0;

  assign out_data_d = {3'b000, rd_byte, fin, (cmd_d != CMD_IDLE), drv_d, sda_d, scl_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= UnitTicksRst;
      cmd_q        <= CMD_IDLE;
      phase_q      <= '0;
      bit_cnt_q    <= '0;
      tick_cnt_q   <= '0;
      unit_cnt_q   <= '0;
      shift_q      <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      drv_q        <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_ticks_q <= cfg_wdata_i;
      end
      if (req_fire) begin
        cmd_q      <= cmd_d;
        phase_q    <= phase_d;
        bit_cnt_q  <= bit_cnt_d;
        tick_cnt_q <= tick_cnt_d;
        unit_cnt_q <= unit_cnt_d;
        shift_q    <= shift_d;
        scl_q      <= scl_d;
        sda_q      <= sda_d;
        drv_q      <= drv_d;
      end
      if (req_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cms_checker.sv =====
// i2cms_checker: port-level assertions for the i2c master bit sequencer,
// bound to i2c_master_bit_sequencer_core; depends on i2cms_pkg
`default_nettype none

module i2cms_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [i2cms_pkg::OutDataW-1:0]  m_axis_tdata
);
  import i2cms_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no new request while the result register is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken into a full result register");

  // every accepted request shows a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request without result");

  // done and busy never together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]))
    else $error("done while busy");

  // read byte shown only on done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[12:5] == 8'd0)
    else $error("read byte without done");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for i2c_master_bit_sequencer_core, one bus tick per request,
// every result compared against a cycle-level model of the scl/sda sequencing
// depends on i2cms_pkg and i2c_master_bit_sequencer_core
`default_nettype none

module tb;
  import i2cms_pkg::*;

  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] rd;
    logic       done;
    logic       busy;
    logic       drv;
    logic       sda;
    logic       scl;
  } lines_t;

  typedef struct packed {
    logic                  wr_cfg;
    logic [UnitTicksW-1:0] cfg;
    logic [2:0]            act;
    logic [7:0]            wb;
    logic [7:0]            sda_pat;
    logic                  noisy;
    logic                  typed;
    lines_t                want;
  } row_t;

  localparam logic [2:0] ActBogus = 3'd7;
  localparam logic [UnitTicksW-1:0] UnitMax = 16'hFFFF;
  localparam int NumRows = 17;
  localparam int RandTicks = 900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [UnitTicksW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  always #5 clk_i = ~clk_i;

  i2c_master_bit_sequencer_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // model state
  cmd_e                  cur_cmd;
  logic [2:0]            cur_phase;
  logic [3:0]            bit_idx;
  int unsigned           tick_ctr;
  logic [2:0]            unit_ctr;
  logic [7:0]            shifter;
  logic                  scl_q, sda_q, drv_q;
  logic [UnitTicksW-1:0] unit_len;

  lines_t pending_lines[$];
  int errors = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int rand_ticks = 0;
  int cmds_started = 0;
  int cfg_writes = 0;
  int holds_done = 0;
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  int rx_wait = 0;

  function automatic lines_t mk(input int scl, input int sda, input int drv,
                                input int done, input logic [7:0] rd);
    lines_t r;
    r = '0;
    r.scl = scl[0];
    r.sda = sda[0];
    r.drv = drv[0];
    r.done = done[0];
    r.rd = rd;
    return r;
  endfunction

  function automatic logic unit_elapsed(input logic [2:0] units);
    int unsigned lim;
    lim = (unit_len == '0) ? 32'd1 : 32'(unit_len);
    tick_ctr++;
    if (tick_ctr >= lim) begin
      tick_ctr = 0;
      unit_ctr = unit_ctr + 3'd1;
    end
    if (unit_ctr >= units) begin
      unit_ctr = '0;
      tick_ctr = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic lines_t bus_tick(input logic [2:0] act, input logic [7:0] wb,
                                      input logic sda_in);
    lines_t r;
    logic fin;
    r = '0;
    fin = 1'b0;
    if (cur_cmd == CMD_IDLE) begin
      if (act >= CMD_START && act <= CMD_READ) begin
        cur_cmd = cmd_e'(act);
        cur_phase = '0;
        bit_idx = '0;
        tick_ctr = 0;
        unit_ctr = '0;
        case (cur_cmd)
          CMD_START: {scl_q, sda_q, drv_q} = 3'b111;
          CMD_STOP:  {scl_q, sda_q, drv_q} = 3'b101;
          CMD_ACK:   {scl_q, sda_q, drv_q} = 3'b001;
          CMD_NACK:  {scl_q, sda_q, drv_q} = 3'b011;
          CMD_WRITE: begin
            {scl_q, sda_q, drv_q} = 3'b011;
            sda_q = wb[7];
            shifter = {wb[6:0], 1'b0};
          end
          default: begin
            {scl_q, sda_q, drv_q} = 3'b010;
            shifter = '0;
          end
        endcase
      end
    end else begin
      case (cur_cmd)
        CMD_START: if (unit_elapsed(UnitsLong)) begin
          if (cur_phase == 3'd0) begin
            sda_q = 1'b0;
            cur_phase = 3'd1;
          end else begin
            scl_q = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_STOP: if (unit_elapsed(UnitsLong)) begin
          if (cur_phase == 3'd0) begin
            sda_q = 1'b1;
            cur_phase = 3'd1;
          end else begin
            fin = 1'b1;
          end
        end
        CMD_ACK, CMD_NACK: if (unit_elapsed(UnitsShort)) begin
          if (cur_phase == 3'd0) begin
            scl_q = 1'b1;
            cur_phase = 3'd1;
          end else begin
            scl_q = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_WRITE: if (unit_elapsed(UnitsShort)) begin
          if (cur_phase == 3'd0) begin
            scl_q = 1'b1;
            cur_phase = 3'd1;
          end else if (cur_phase == 3'd1) begin
            scl_q = 1'b0;
            cur_phase = 3'd2;
          end else begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= BitsPerByte) begin
              fin = 1'b1;
            end else begin
              sda_q = shifter[7];
              shifter = {shifter[6:0], 1'b0};
              cur_phase = 3'd0;
            end
          end
        end
        CMD_READ: begin
          if (cur_phase == 3'd0) begin
            if (unit_elapsed(UnitsShort)) begin
              scl_q = 1'b1;
              shifter = {shifter[6:0], sda_in};
              cur_phase = 3'd1;
            end
          end else if (unit_elapsed(UnitsOne)) begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= BitsPerByte) begin
              fin = 1'b1;
            end else begin
              scl_q = 1'b0;
              cur_phase = 3'd0;
            end
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        if (cur_cmd == CMD_READ) r.rd = shifter;
        cur_cmd = CMD_IDLE;
        cur_phase = '0;
        r.done = 1'b1;
      end
    end
    r.scl = scl_q;
    r.sda = sda_q;
    r.drv = drv_q;
    r.busy = (cur_cmd != CMD_IDLE);
    return r;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 50) $display("ERROR result %0d: %s", results_seen, what);
  endtask

  task automatic check_lines(input lines_t got);
    lines_t want;
    if (pending_lines.size() == 0) begin
      report("result with nothing pending");
      return;
    end
    want = pending_lines.pop_front();
    if (got.scl !== want.scl) report($sformatf("scl %b, want %b", got.scl, want.scl));
    if (got.sda !== want.sda) report($sformatf("sda %b, want %b", got.sda, want.sda));
    if (got.drv !== want.drv) report($sformatf("sda_drive %b, want %b", got.drv, want.drv));
    if (got.busy !== want.busy) report($sformatf("busy %b, want %b", got.busy, want.busy));
    if (got.done !== want.done) report($sformatf("done %b, want %b", got.done, want.done));
    if (got.rd !== want.rd) report($sformatf("read_data %h, want %h", got.rd, want.rd));
  endtask

  // result side: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_lines(lines_t'(m_axis_tdata));
      results_seen++;
    end
    if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else if (hold_req && holds_done == 0) begin
      holds_done++;
      rx_wait <= 300;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_wait <= $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_tick(input logic [2:0] act, input logic [7:0] wb, input logic sda,
                           input logic typed, input lines_t want);
    lines_t r;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, sda, wb, act};
    do @(posedge clk_i); while (!s_axis_tready);
    r = bus_tick(act, wb, sda);
    if (typed && !r.busy) pending_lines.push_back(want);
    else pending_lines.push_back(r);
    ticks_sent++;
  endtask

  task automatic run_out();
    while (cur_cmd != CMD_IDLE) begin
      send_tick(CMD_IDLE, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_unit(input logic [UnitTicksW-1:0] v);
    run_out();
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unit_len = v;
    cfg_writes++;
  endtask

  row_t plan[NumRows];

  initial begin
    row_t step_row;
    logic [2:0] act;
    logic sda;
    int len;
    int phase_no;

    cur_cmd = CMD_IDLE;
    cur_phase = '0;
    bit_idx = '0;
    tick_ctr = 0;
    unit_ctr = '0;
    shifter = '0;
    {scl_q, sda_q, drv_q} = 3'b111;
    unit_len = UnitTicksRst;

    plan = '{
      '{1'b0, 16'd0,   CMD_IDLE,  8'h00, 8'h00, 1'b0, 1'b1, mk(1, 1, 1, 0, 8'h00)},
      '{1'b0, 16'd0,   ActBogus,  8'hFF, 8'h00, 1'b0, 1'b1, mk(1, 1, 1, 0, 8'h00)},
      '{1'b0, 16'd0,   CMD_START, 8'h00, 8'h00, 1'b0, 1'b1, mk(0, 0, 1, 1, 8'h00)},
      '{1'b1, 16'd1,   CMD_STOP,  8'h00, 8'h00, 1'b0, 1'b1, mk(1, 1, 1, 1, 8'h00)},
      '{1'b0, 16'd0,   CMD_ACK,   8'h00, 8'h00, 1'b0, 1'b1, mk(0, 0, 1, 1, 8'h00)},
      '{1'b0, 16'd0,   CMD_NACK,  8'h00, 8'h00, 1'b0, 1'b1, mk(0, 1, 1, 1, 8'h00)},
      '{1'b0, 16'd0,   CMD_WRITE, 8'h00, 8'h00, 1'b0, 1'b1, mk(0, 0, 1, 1, 8'h00)},
      '{1'b0, 16'd0,   CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1, mk(0, 1, 1, 1, 8'h00)},
      '{1'b1, 16'd2,   CMD_WRITE, 8'hA5, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 16'd0,   CMD_READ,  8'h00, 8'hFF, 1'b0, 1'b1, mk(1, 1, 0, 1, 8'hFF)},
      '{1'b0, 16'd0,   CMD_READ,  8'hFF, 8'h00, 1'b0, 1'b1, mk(1, 1, 0, 1, 8'h00)},
      '{1'b0, 16'd0,   CMD_READ,  8'h00, 8'h5A, 1'b0, 1'b0, '0},
      // zero ticks per unit behaves as one
      '{1'b1, 16'd0,   CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, '0},
      // commands offered while busy are dropped
      '{1'b0, 16'd0,   CMD_WRITE, 8'h3C, 8'h00, 1'b1, 1'b0, '0},
      '{1'b1, 16'd3,   CMD_READ,  8'h00, 8'hC3, 1'b1, 1'b0, '0},
      '{1'b0, 16'd0,   CMD_NACK,  8'h81, 8'h00, 1'b1, 1'b0, '0},
      '{1'b1, UnitMax, CMD_IDLE,  8'h7E, 8'h00, 1'b0, 1'b1, mk(0, 1, 1, 0, 8'h00)}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      step_row = plan[i];
      if (step_row.wr_cfg) set_unit(step_row.cfg);
      if (step_row.act >= CMD_START && step_row.act <= CMD_READ) cmds_started++;
      send_tick(step_row.act, step_row.wb, 1'($urandom_range(0, 1)), step_row.typed,
                step_row.want);
      while (cur_cmd != CMD_IDLE) begin
        act = step_row.noisy ? 3'($urandom_range(0, 7)) : 3'(CMD_IDLE);
        sda = (cur_cmd == CMD_READ) ? step_row.sda_pat[~bit_idx[2:0]]
                                    : 1'($urandom_range(0, 1));
        send_tick(act, 8'($urandom), sda, step_row.typed, step_row.want);
      end
    end

    phase_no = 0;
    while (rand_ticks < RandTicks) begin
      phase_no++;
      case ($urandom_range(0, 5))
        0: set_unit('0);
        1: set_unit(16'd1);
        default: set_unit(16'($urandom_range(1, 4)));
      endcase
      idle_on = (rand_ticks < RandTicks - 300);
      if (phase_no == 2) hold_req <= 1'b1;
      len = $urandom_range(80, 200);
      for (int k = 0; k < len; k++) begin
        // sender pause until every result is back, mid-command
        if (phase_no == 3 && k == len / 2) drain();
        if (cur_cmd == CMD_IDLE) begin
          if ($urandom_range(0, 6) != 0) act = 3'($urandom_range(1, 6));
          else act = $urandom_range(0, 1) ? ActBogus : 3'(CMD_IDLE);
          if (act >= CMD_START && act <= CMD_READ) cmds_started++;
        end else begin
          act = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'(CMD_IDLE);
        end
        send_tick(act, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
        rand_ticks++;
      end
      run_out();
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("run covered %0d ticks, %0d bus commands, %0d unit_ticks writes",
             ticks_sent, cmds_started, cfg_writes);
    $display("checked %0d results, %0d long result hold-offs", results_seen, holds_done);
    if (errors == 0 && pending_lines.size() == 0) begin
      $display("i2c_master_bit_sequencer_core verification clean");
    end else begin
      $display("i2c_master_bit_sequencer_core verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results pending", pending_lines.size());
    $display("i2c_master_bit_sequencer_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/i2cms_pkg.sv
sv/i2c_master_bit_sequencer_core.sv
sv/i2cms_checker.sv
sim/tb.sv
